// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/ttps_pkg.sv =====
// Types, codes and score helpers for the transposition table.
`timescale 1ns / 1ps
`default_nettype none

package ttps_pkg;

	localparam int KEY_W = 64;
	localparam int MT_W = 15;
	localparam int DIGIT = 8;
	localparam int STEPS = KEY_W / DIGIT;

	localparam logic [MT_W-1:0] MATE_RESET = 15'd29936;

	localparam logic [1:0] FUNC_PROBE = 2'd0;
	localparam logic [1:0] FUNC_STORE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] BOUND_UPPER = 2'd0;
	localparam logic [1:0] BOUND_LOWER = 2'd1;
	localparam logic [1:0] BOUND_EXACT = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [63:0]       key;
		logic [5:0]        ply;
		logic [5:0]        search_depth;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic [24:0]       move_in;
		logic signed [15:0] score_in;
		logic [1:0]        bound_kind;
	} req_t;

	typedef struct packed {
		logic              key_found;
		logic [24:0]       move_out;
		logic              cutoff;
		logic signed [15:0] score_out;
		logic              was_empty;
		logic [31:0]       hit_total;
		logic [31:0]       new_write_total;
		logic [31:0]       overwrite_total;
	} rsp_t;

	typedef struct packed {
		logic [63:0]       key;
		logic [24:0]       move;
		logic [5:0]        depth;
		logic signed [15:0] score;
		logic [1:0]        bound;
	} entry_t;

	// Mate scores move away from zero by ply on store, back toward zero on probe.
	function automatic logic signed [15:0] mate_adjust(input logic signed [15:0] s,
			input logic [5:0] ply, input logic [MT_W-1:0] mt, input logic to_store);
		logic signed [17:0] v;
		logic signed [17:0] lim;
		logic signed [17:0] d;
		v = 18'(s);
		lim = $signed({3'b000, mt});
		d = $signed({12'b0, ply});
		if (v > lim) begin
			v = to_store ? v + d : v - d;
		end else if (v < -lim) begin
			v = to_store ? v - d : v + d;
		end
		if (v > 18'sd32767) begin
			return 16'sh7fff;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ttps_fifo.sv =====
// Two-entry request queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttps_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	logic [W-1:0] buf_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_wr;
	logic         do_rd;

	assign full = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= 2'd2)
	`ASSERT_IMPL(a_ptr_track, clk, arst_n, count_q == 2'd0 || count_q == 2'd2, wr_ptr_q == rd_ptr_q)

endmodule

`default_nettype wire

// ===== rtl/ttps_front.sv =====
// Front end: takes a request, reduces the key to a slot index, pre-adjusts store scores.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttps_front #(
	parameter int ENTRIES = 4096,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ttps_pkg::MT_W-1:0]  mt,
	input  logic                       push,
	input  ttps_pkg::req_t             req,
	output logic                       full,
	input  logic                       init_busy,
	input  logic                       q_full,
	output logic                       q_push,
	output ttps_pkg::req_t             q_cmd,
	output logic [IW-1:0]              q_idx
);

	localparam bit POW2 = (ENTRIES & (ENTRIES - 1)) == 0;
	localparam logic [IW:0] ENT = (IW + 1)'(ENTRIES);
	localparam logic [3:0] NSTEP = 4'(ttps_pkg::STEPS);

	logic                         busy_q;
	ttps_pkg::req_t               req_q;
	logic [ttps_pkg::KEY_W-1:0]   sh_q;
	logic [IW-1:0]                rem_q;
	logic [3:0]                   left_q;
	logic [IW-1:0]                rem_nx;
	logic [IW-1:0]                r;
	logic [IW:0]                  t;
	logic                         done;
	logic                         accept;

	assign full = busy_q || init_busy;
	assign accept = push && !full;
	assign done = busy_q && left_q == 4'd0;
	assign q_push = done && !q_full;
	assign q_idx = POW2 ? req_q.key[IW-1:0] : rem_q;

	// one byte of the key per cycle, MSB first, restoring reduction
	always_comb begin
		r = rem_q;
		t = '0;
		for (int i = 0; i < ttps_pkg::DIGIT; i++) begin
			t = {r, sh_q[ttps_pkg::KEY_W-1-i]};
			if (t >= ENT) begin
				t = t - ENT;
			end
			r = t[IW-1:0];
		end
		rem_nx = r;
	end

	always_comb begin
		q_cmd = req_q;
		q_cmd.score_in = ttps_pkg::mate_adjust(req_q.score_in, req_q.ply, mt, 1'b1);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			sh_q <= req.key;
			rem_q <= '0;
		end else if (busy_q && left_q != 4'd0) begin
			sh_q <= sh_q << ttps_pkg::DIGIT;
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= 4'd0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				left_q <= POW2 ? 4'd0 : NSTEP;
			end else if (q_push) begin
				busy_q <= 1'b0;
			end else if (busy_q && left_q != 4'd0) begin
				left_q <= left_q - 4'd1;
			end
		end
	end

	`ASSERT_IMPL(a_idx_range, clk, arst_n, q_push, {1'b0, q_idx} < ENT)
	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, accept, !busy_q && !init_busy)

endmodule

`default_nettype wire

// ===== rtl/ttps_back.sv =====
// Back end: entry memory, probe/store/clear sequencing, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttps_back #(
	parameter int ENTRIES = 4096,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ttps_pkg::MT_W-1:0]  mt,
	input  logic                       q_empty,
	input  ttps_pkg::req_t             q_cmd,
	input  logic [IW-1:0]              q_idx,
	output logic                       q_pop,
	output logic                       init_busy,
	output logic                       empty,
	input  logic                       pop,
	output ttps_pkg::rsp_t             rsp
);

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	state_t              state_q;
	ttps_pkg::req_t      cmd_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       clr_addr_q;
	logic                report_q;
	logic [31:0]         hit_cnt_q;
	logic [31:0]         new_cnt_q;
	logic [31:0]         ovr_cnt_q;
	logic                found_q;
	logic                hit_q;
	logic                empty_q;
	logic [24:0]         move_q;
	logic signed [15:0]  sc_q;
	logic [1:0]          bound_q;
	logic                out_valid_q;
	ttps_pkg::rsp_t      rsp_q;

	ttps_pkg::entry_t    mem [ENTRIES];
	ttps_pkg::entry_t    rd_q;
	ttps_pkg::entry_t    wr_data;
	logic [IW-1:0]       wr_addr;
	logic                wr_en;
	logic                rd_en;

	logic                match;
	logic                deep;
	logic                slot_empty;
	logic signed [15:0]  adj;
	logic                out_load;
	logic                cut;
	logic signed [15:0]  sc_fin;
	ttps_pkg::rsp_t      rsp_nx;

	assign init_busy = state_q == ST_CLR && !report_q;
	assign empty = !out_valid_q;
	assign rsp = rsp_q;

	assign q_pop = state_q == ST_IDLE && !q_empty;
	assign rd_en = q_pop && (q_cmd.func == ttps_pkg::FUNC_PROBE ||
		q_cmd.func == ttps_pkg::FUNC_STORE);

	assign match = rd_q.key == cmd_q.key;
	assign deep = rd_q.depth >= cmd_q.search_depth;
	assign slot_empty = rd_q.key == '0;
	assign adj = ttps_pkg::mate_adjust(rd_q.score, cmd_q.ply, mt, 1'b0);

	assign wr_en = state_q == ST_CLR ||
		(state_q == ST_EXEC && cmd_q.func == ttps_pkg::FUNC_STORE);
	assign wr_addr = state_q == ST_CLR ? clr_addr_q : idx_q;

	always_comb begin
		wr_data = '0;
		if (state_q != ST_CLR) begin
			wr_data.key = cmd_q.key;
			wr_data.move = cmd_q.move_in;
			wr_data.depth = cmd_q.search_depth;
			wr_data.score = cmd_q.score_in;
			wr_data.bound = cmd_q.bound_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[q_idx];
		end
	end

	// bound test against the window
	always_comb begin
		cut = 1'b0;
		sc_fin = hit_q ? sc_q : 16'sd0;
		if (hit_q) begin
			case (bound_q)
				ttps_pkg::BOUND_UPPER: begin
					if (sc_q <= cmd_q.alpha) begin
						sc_fin = cmd_q.alpha;
						cut = 1'b1;
					end
				end
				ttps_pkg::BOUND_LOWER: begin
					if (sc_q >= cmd_q.beta) begin
						sc_fin = cmd_q.beta;
						cut = 1'b1;
					end
				end
				ttps_pkg::BOUND_EXACT: cut = 1'b1;
				default: cut = 1'b0;
			endcase
		end
	end

	always_comb begin
		rsp_nx = '0;
		rsp_nx.hit_total = hit_cnt_q;
		rsp_nx.new_write_total = new_cnt_q;
		rsp_nx.overwrite_total = ovr_cnt_q;
		if (cmd_q.func == ttps_pkg::FUNC_PROBE) begin
			rsp_nx.key_found = found_q;
			rsp_nx.move_out = found_q ? move_q : '0;
			rsp_nx.cutoff = cut;
			rsp_nx.score_out = sc_fin;
		end else if (cmd_q.func == ttps_pkg::FUNC_STORE) begin
			rsp_nx.was_empty = empty_q;
		end
	end

	assign out_load = state_q == ST_DONE && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_addr_q <= '0;
			report_q <= 1'b0;
			hit_cnt_q <= '0;
			new_cnt_q <= '0;
			ovr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				rsp_q <= rsp_nx;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST) begin
						clr_addr_q <= '0;
						new_cnt_q <= '0;
						state_q <= report_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						cmd_q <= q_cmd;
						idx_q <= q_idx;
						unique case (q_cmd.func) inside
							ttps_pkg::FUNC_PROBE, ttps_pkg::FUNC_STORE: state_q <= ST_EXEC;
							ttps_pkg::FUNC_CLEAR: begin
								report_q <= 1'b1;
								state_q <= ST_CLR;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_EXEC: begin
					found_q <= match;
					hit_q <= match && deep;
					empty_q <= slot_empty;
					move_q <= rd_q.move;
					sc_q <= adj;
					bound_q <= rd_q.bound;
					if (cmd_q.func == ttps_pkg::FUNC_PROBE) begin
						if (match && deep) begin
							hit_cnt_q <= hit_cnt_q + 32'd1;
						end
					end else if (slot_empty) begin
						new_cnt_q <= new_cnt_q + 32'd1;
					end else begin
						ovr_cnt_q <= ovr_cnt_q + 32'd1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						report_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_one_port, clk, arst_n, !(wr_en && rd_en))
	`ASSERT_NEXT(a_read_exec, clk, arst_n, rd_en, state_q == ST_EXEC)

endmodule

`default_nettype wire

// ===== rtl/transposition_table_probe_store.sv =====
// Top level of the direct-mapped always-replace transposition table.
// Probe and store go through the front end, the two-entry queue and the back end;
//   the front end adds a byte-serial key reduction when ENTRIES is not a power of two.
// Each probe or store runs the read-then-write sequence on the single-port entry
//   memory; the front end can take the next request while the back end works.
// Reset: asynchronous; a clearing pass then zeroes the memory with full held high.
`timescale 1ns / 1ps
`default_nettype none

module transposition_table_probe_store #(
	parameter int ENTRIES = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  ttps_pkg::req_t             req,
	output logic                       empty,
	input  logic                       pop,
	output ttps_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [ttps_pkg::MT_W-1:0]  cfg_wdata
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $bits(ttps_pkg::req_t);
	localparam int QW = CW + IW;

	logic [ttps_pkg::MT_W-1:0] mt_q;
	logic                      init_busy;
	logic                      q_full;
	logic                      q_push;
	ttps_pkg::req_t            f_cmd;
	logic [IW-1:0]             f_idx;
	logic [QW-1:0]             q_rd_data;
	logic                      q_empty;
	logic                      q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_q <= ttps_pkg::MATE_RESET;
		end else if (cfg_we) begin
			mt_q <= cfg_wdata;
		end
	end

	ttps_front #(
		.ENTRIES(ENTRIES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.mt(mt_q),
		.push(push),
		.req(req),
		.full(full),
		.init_busy(init_busy),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(f_cmd),
		.q_idx(f_idx)
	);

	ttps_fifo #(
		.W(QW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(q_push),
		.wr_data({f_idx, f_cmd}),
		.full(q_full),
		.rd_en(q_pop),
		.rd_data(q_rd_data),
		.empty(q_empty)
	);

	ttps_back #(
		.ENTRIES(ENTRIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mt(mt_q),
		.q_empty(q_empty),
		.q_cmd(ttps_pkg::req_t'(q_rd_data[CW-1:0])),
		.q_idx(q_rd_data[QW-1:CW]),
		.q_pop(q_pop),
		.init_busy(init_busy),
		.empty(empty),
		.pop(pop),
		.rsp(rsp)
	);

endmodule

`default_nettype wire

// ===== verif/tb_transposition_table_probe_store.sv =====
// Self-checking testbench for the transposition table: predicted probe/store/clear replies.
`timescale 1ns / 1ps

module tb_transposition_table_probe_store;

	localparam int ENTRIES = 4096;
	localparam int SLOT_W = $clog2(ENTRIES);
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam logic [1:0] BOUND_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	ttps_pkg::req_t req = '0;
	logic empty;
	logic pop = 1'b0;
	ttps_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [ttps_pkg::MT_W-1:0] cfg_wdata = ttps_pkg::MATE_RESET;

	// table image kept by the predictor
	logic [63:0] tbl_key [ENTRIES];
	logic [24:0] tbl_move [ENTRIES];
	logic [5:0] tbl_depth [ENTRIES];
	logic signed [15:0] tbl_score [ENTRIES];
	logic [1:0] tbl_bound [ENTRIES];
	logic [31:0] hit_cnt;
	logic [31:0] new_write_cnt;
	logic [31:0] overwrite_cnt;
	logic [ttps_pkg::MT_W-1:0] mate_lim;

	ttps_pkg::req_t pending_ops[$];
	ttps_pkg::rsp_t expected_replies[$];
	logic [63:0] key_pool[$];

	int send_idle_pct = 11;
	int recv_idle_pct = 48;
	int fail_count = 0;
	int unsigned cycle_count = 0;

	transposition_table_probe_store #(.ENTRIES(ENTRIES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return 16'(v);
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_key[i] = '0;
			tbl_move[i] = '0;
			tbl_depth[i] = '0;
			tbl_score[i] = '0;
			tbl_bound[i] = '0;
		end
		new_write_cnt = '0;
	endfunction

	function automatic ttps_pkg::rsp_t apply_table_op(input ttps_pkg::req_t r);
		ttps_pkg::rsp_t o;
		logic [SLOT_W-1:0] slot;
		int sc;
		int lim;
		int p;
		int a;
		int b;
		o = '0;
		slot = r.key[SLOT_W-1:0];
		lim = int'(mate_lim);
		p = int'(r.ply);
		a = $signed(r.alpha);
		b = $signed(r.beta);
		case (r.func)
			ttps_pkg::FUNC_PROBE: begin
				if (tbl_key[slot] == r.key) begin
					o.key_found = 1'b1;
					o.move_out = tbl_move[slot];
					if (tbl_depth[slot] >= r.search_depth) begin
						hit_cnt++;
						sc = $signed(tbl_score[slot]);
						if (sc > lim) begin
							sc -= p;
						end else if (sc < -lim) begin
							sc += p;
						end
						sc = clamp16(sc);
						case (tbl_bound[slot])
							ttps_pkg::BOUND_UPPER: begin
								if (sc <= a) begin
									sc = a;
									o.cutoff = 1'b1;
								end
							end
							ttps_pkg::BOUND_LOWER: begin
								if (sc >= b) begin
									sc = b;
									o.cutoff = 1'b1;
								end
							end
							ttps_pkg::BOUND_EXACT: begin
								o.cutoff = 1'b1;
							end
							default: ;
						endcase
						o.score_out = 16'(sc);
					end
				end
			end
			ttps_pkg::FUNC_STORE: begin
				if (tbl_key[slot] == '0) begin
					new_write_cnt++;
					o.was_empty = 1'b1;
				end else begin
					overwrite_cnt++;
				end
				sc = $signed(r.score_in);
				if (sc > lim) begin
					sc += p;
				end else if (sc < -lim) begin
					sc -= p;
				end
				tbl_key[slot] = r.key;
				tbl_move[slot] = r.move_in;
				tbl_depth[slot] = r.search_depth;
				tbl_score[slot] = clamp16(sc);
				tbl_bound[slot] = r.bound_kind;
			end
			ttps_pkg::FUNC_CLEAR: begin
				wipe_table();
			end
			default: ;
		endcase
		o.hit_total = hit_cnt;
		o.new_write_total = new_write_cnt;
		o.overwrite_total = overwrite_cnt;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0h, actual %0h", name, e, a);
			fail_count++;
		end
	endtask

	// driver: one request per handshake, held while full
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				expected_replies.push_back(apply_table_op(req));
				void'(pending_ops.pop_front());
			end
			if (!(push && full)) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					push <= 1'b1;
					req <= pending_ops[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		ttps_pkg::rsp_t exp_rsp;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_replies.size() == 0) begin
					$error("reply with no request outstanding");
					fail_count++;
				end else begin
					exp_rsp = expected_replies.pop_front();
					check_field("key_found", exp_rsp.key_found, rsp.key_found);
					check_field("move_out", exp_rsp.move_out, rsp.move_out);
					check_field("cutoff", exp_rsp.cutoff, rsp.cutoff);
					check_field("score_out", exp_rsp.score_out, rsp.score_out);
					check_field("was_empty", exp_rsp.was_empty, rsp.was_empty);
					check_field("hit_total", exp_rsp.hit_total, rsp.hit_total);
					check_field("new_write_total", exp_rsp.new_write_total,
						rsp.new_write_total);
					check_field("overwrite_total", exp_rsp.overwrite_total,
						rsp.overwrite_total);
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** transposition_table_probe_store: FAILED **");
			$finish;
		end
	end

	task automatic write_mate_limit(input logic [ttps_pkg::MT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		mate_lim = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || expected_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_op(input logic [1:0] f, input logic [63:0] k, input int p, input int d,
			input int a, input int b, input logic [24:0] m, input int s, input logic [1:0] bk);
		ttps_pkg::req_t r;
		r.func = f;
		r.key = k;
		r.ply = 6'(p);
		r.search_depth = 6'(d);
		r.alpha = 16'(a);
		r.beta = 16'(b);
		r.move_in = m;
		r.score_in = 16'(s);
		r.bound_kind = bk;
		pending_ops.push_back(r);
	endtask

	function automatic logic signed [15:0] pick_score();
		int lim;
		int j;
		lim = int'(mate_lim);
		j = $urandom_range(200);
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return clamp16(lim + (j % 3) - 1);
			2: return clamp16(-lim - (j % 3) + 1);
			3: return 16'sh7fff;
			4: return 16'sh8000;
			default: return clamp16(j - 100);
		endcase
	endfunction

	function automatic logic [63:0] fresh_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		if ($urandom_range(1) == 0) begin
			k[SLOT_W-1:0] = SLOT_W'($urandom_range(31));
		end
		return k;
	endfunction

	task automatic queue_random_op();
		ttps_pkg::req_t r;
		int pick;
		int kp;
		pick = $urandom_range(999);
		kp = $urandom_range(99);
		r.ply = 6'($urandom);
		r.search_depth = 6'($urandom);
		r.alpha = ($urandom_range(3) == 0) ? 16'($urandom) : pick_score();
		r.beta = ($urandom_range(3) == 0) ? 16'($urandom) : pick_score();
		r.move_in = ($urandom_range(9) == 0) ? 25'd0 : 25'($urandom);
		r.score_in = pick_score();
		r.bound_kind = 2'($urandom_range(3));
		r.key = fresh_key();
		if (pick < 5) begin
			r.func = ttps_pkg::FUNC_CLEAR;
			key_pool.delete();
		end else if (pick < 35) begin
			r.func = FUNC_NOP;
		end else if (pick < 500) begin
			r.func = ttps_pkg::FUNC_STORE;
			if (kp < 35 && key_pool.size() != 0) begin
				r.key = key_pool[$urandom_range(key_pool.size() - 1)];
			end else if (kp < 40) begin
				r.key = '0;
			end else begin
				key_pool.push_back(r.key);
				if (key_pool.size() > 48) begin
					void'(key_pool.pop_front());
				end
			end
		end else begin
			r.func = ttps_pkg::FUNC_PROBE;
			if (kp < 70 && key_pool.size() != 0) begin
				r.key = key_pool[$urandom_range(key_pool.size() - 1)];
			end else if (kp < 80) begin
				r.key = '0;
			end
		end
		pending_ops.push_back(r);
	endtask

	initial begin
		logic [63:0] k1;
		logic [63:0] k2;
		logic [63:0] k3;
		logic [ttps_pkg::MT_W-1:0] lim_v;
		k1 = 64'hFFFF_FFFF_FFFF_FFFF;
		k2 = 64'h8000_0000_0000_0FFF;
		k3 = 64'h0000_0000_0000_0001;
		wipe_table();
		hit_cnt = '0;
		overwrite_cnt = '0;
		mate_lim = ttps_pkg::MATE_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_mate_limit(ttps_pkg::MATE_RESET);

		queue_op(ttps_pkg::FUNC_PROBE, 64'd0, 0, 0, 0, 0, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_STORE, k1, 63, 63, 0, 0, '1, 32767, ttps_pkg::BOUND_EXACT);
		queue_op(ttps_pkg::FUNC_PROBE, k1, 63, 63, -32768, 32767, 25'd0, 0,
			ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_STORE, k1, 63, 0, 0, 0, 25'h155_5555, -32768,
			ttps_pkg::BOUND_LOWER);
		queue_op(ttps_pkg::FUNC_PROBE, k1, 63, 0, 32767, -32768, 25'd0, 0,
			ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_PROBE, k1, 0, 0, 0, 32767, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_STORE, k2, 5, 5, 0, 0, 25'h0AA_AAAA, 100,
			ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_PROBE, k1, 0, 0, 0, 0, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_PROBE, k2, 0, 63, 0, 0, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_PROBE, k2, 0, 5, 200, 0, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_PROBE, k2, 0, 0, -200, 0, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_STORE, k3, 10, 7, 0, 0, 25'h1, 29937, BOUND_NONE);
		queue_op(ttps_pkg::FUNC_PROBE, k3, 3, 7, -32768, 32767, 25'd0, 0,
			ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_STORE, 64'd0, 0, 1, 0, 0, 25'd0, -29937,
			ttps_pkg::BOUND_EXACT);
		queue_op(ttps_pkg::FUNC_PROBE, 64'd0, 33, 0, 0, 0, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(FUNC_NOP, k1, 63, 63, -1, -1, '1, -1, BOUND_NONE);
		queue_op(ttps_pkg::FUNC_CLEAR, k1, 0, 0, 0, 0, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_PROBE, k2, 0, 0, 0, 0, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		queue_op(ttps_pkg::FUNC_STORE, k2, 1, 2, 0, 0, 25'h7, -5, ttps_pkg::BOUND_LOWER);
		queue_op(ttps_pkg::FUNC_PROBE, k2, 1, 2, 0, -10, 25'd0, 0, ttps_pkg::BOUND_UPPER);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim_v = '0;
				1: lim_v = '1;
				2: lim_v = ttps_pkg::MT_W'($urandom_range(32767));
				3: lim_v = ttps_pkg::MT_W'($urandom_range(29000, 32000));
				4: lim_v = 15'd100;
				default: lim_v = ttps_pkg::MATE_RESET;
			endcase
			write_mate_limit(lim_v);
			if (ph < 2) begin
				send_idle_pct = 11;
				recv_idle_pct = 48;
			end else if (ph < 4) begin
				send_idle_pct = 48;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (235) queue_random_op();
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("** transposition_table_probe_store: PASSED **");
		end else begin
			$display("** transposition_table_probe_store: FAILED **");
		end
		$finish;
	end

endmodule
